// File: design/bdq_pkg.sv
// bdq_pkg: shared constants, codes, control/status structs and ring index helpers
// for the bounded double-ended queue; used by every other design file but bdq_ram
`default_nettype none

package bdq_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int WORD_W  = 32;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int DROP_W  = 16;
    localparam int ENTRY_W = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;
    localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADN  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic dump_step;
    } bdq_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic dump_last;
    } bdq_stat_t;

    // both operands below DEPTH
    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= SUM_W'(DEPTH))
        begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0)
        begin
            r = IDX_W'(DEPTH - 1);
        end
        else
        begin
            r = a - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/bdq_req_if.sv
// bdq_req_if: command channel of the queue, valid/ready with the command payload
// depends on bdq_pkg for field widths
`default_nettype none

interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [bdq_pkg::CMD_W-1:0]           command;
    logic [bdq_pkg::WORD_W-1:0]          value;
    logic signed [bdq_pkg::DROP_W-1:0]   drop_count;

    modport source (output valid, output command, output value, output drop_count,
                    input ready);
    modport sink   (input valid, input command, input value, input drop_count,
                    output ready);
endinterface

`default_nettype wire

// File: design/bdq_rsp_if.sv
// bdq_rsp_if: result channel of the queue, valid/ready with the result payload
// depends on bdq_pkg for field widths
`default_nettype none

interface bdq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bdq_pkg::STAT_W-1:0]    status;
    logic [bdq_pkg::WORD_W-1:0]    value_out;
    logic [bdq_pkg::ENTRY_W-1:0]   entry_count;
    logic                          last;

    modport source (output valid, output status, output value_out, output entry_count,
                    output last, input ready);
    modport sink   (input valid, input status, input value_out, input entry_count,
                    input last, output ready);
endinterface

`default_nettype wire

// File: design/bdq_ram.sv
// bdq_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while re is low
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/bdq_datapath.sv
// bdq_datapath: head pointer, entry count, dump offset, ring store and result register
// depends on bdq_pkg and bdq_ram
`default_nettype none

module bdq_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bdq_pkg::bdq_ctrl_t                 ctrl,
    input  wire logic [bdq_pkg::CMD_W-1:0]          command,
    input  wire logic [bdq_pkg::WORD_W-1:0]         value,
    input  wire logic signed [bdq_pkg::DROP_W-1:0]  drop_count,
    output bdq_pkg::bdq_stat_t                      stat,
    output logic [bdq_pkg::STAT_W-1:0]              status,
    output logic [bdq_pkg::WORD_W-1:0]              value_out,
    output logic [bdq_pkg::ENTRY_W-1:0]             entry_count,
    output logic                                    last
);

    localparam int IDX_W = bdq_pkg::IDX_W;
    localparam int CNT_W = bdq_pkg::CNT_W;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] offset_reg, offset_next;

    logic [bdq_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [bdq_pkg::WORD_W-1:0]  value_out_reg, value_out_next;
    logic [bdq_pkg::ENTRY_W-1:0] entry_count_reg;
    logic                        last_reg, last_next;
    logic                        load_res;

    logic                        empty, full, dump_last;
    logic                        drop_bad, drop_all;
    logic [bdq_pkg::DROP_W-1:0]  drop_u;

    logic                        we, re;
    logic [IDX_W-1:0]            waddr, raddr;
    logic [bdq_pkg::WORD_W-1:0]  rdata;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(bdq_pkg::DEPTH));
    assign dump_last = ((CNT_W'(offset_reg) + CNT_W'(1)) == count_reg);
    assign drop_u    = drop_count;
    assign drop_bad  = (drop_count == '0) || drop_count[bdq_pkg::DROP_W-1];
    assign drop_all  = (drop_u >= bdq_pkg::DROP_W'(count_reg));

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        offset_next    = offset_reg;
        status_next    = bdq_pkg::ST_OK;
        value_out_next = '0;
        last_next      = 1'b1;
        load_res       = 1'b0;
        we             = 1'b0;
        waddr          = head_reg;
        re             = 1'b0;
        raddr          = head_reg;

        if (ctrl.exec)
        begin
            load_res = 1'b1;
            case (command)
                bdq_pkg::CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        head_next  = bdq_pkg::wrap_dec(head_reg);
                        we         = 1'b1;
                        waddr      = bdq_pkg::wrap_dec(head_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = bdq_pkg::wrap_add(head_reg, count_reg[IDX_W-1:0]);
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = bdq_pkg::wrap_add(head_reg, IDX_W'(1));
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_CLEAR:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                end
                bdq_pkg::CMD_DUMP:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // first read goes out now, results follow as dump steps
                        load_res    = 1'b0;
                        re          = 1'b1;
                        raddr       = head_reg;
                        offset_next = '0;
                    end
                end
                bdq_pkg::CMD_DROP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = bdq_pkg::ST_EMPTY;
                    end
                    else if (drop_bad)
                    begin
                        status_next = bdq_pkg::ST_BADN;
                    end
                    else if (drop_all)
                    begin
                        head_next  = '0;
                        count_next = '0;
                    end
                    else
                    begin
                        // here the drop count is below the entry count, so it fits an index
                        head_next  = bdq_pkg::wrap_add(head_reg, drop_u[IDX_W-1:0]);
                        count_next = count_reg - drop_u[CNT_W-1:0];
                    end
                end
                default:
                begin
                    status_next = bdq_pkg::ST_OK;
                end
            endcase
        end
        else if (ctrl.dump_step)
        begin
            load_res       = 1'b1;
            value_out_next = rdata;
            last_next      = dump_last;
            if (!dump_last)
            begin
                offset_next = offset_reg + IDX_W'(1);
                re          = 1'b1;
                raddr       = bdq_pkg::wrap_add(head_reg, offset_reg + IDX_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            count_reg  <= '0;
            offset_reg <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            count_reg  <= count_next;
            offset_reg <= offset_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            status_reg      <= status_next;
            value_out_reg   <= value_out_next;
            entry_count_reg <= bdq_pkg::ENTRY_W'(count_next);
            last_reg        <= last_next;
        end
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::WORD_W),
        .DEPTH (bdq_pkg::DEPTH),
        .ADDR_W(IDX_W)
    ) u_ring (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(value),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign stat.empty     = empty;
    assign stat.dump_last = dump_last;
    assign status         = status_reg;
    assign value_out      = value_out_reg;
    assign entry_count    = entry_count_reg;
    assign last           = last_reg;

endmodule

`default_nettype wire

// File: design/bdq_ctrl.sv
// bdq_ctrl: state machine for command transfers, dump sequencing and result valid
// depends on bdq_pkg
`default_nettype none

module bdq_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_ready,
    input  wire logic [bdq_pkg::CMD_W-1:0] command,
    output logic                           rsp_valid,
    input  wire logic                      rsp_ready,
    input  wire bdq_pkg::bdq_stat_t        stat,
    output bdq_pkg::bdq_ctrl_t             ctrl
);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free, accept, dump_start, dump_step;

    // result register is free, or its transfer happens this cycle
    assign slot_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept     = req_valid && req_ready;
    assign dump_start = accept && (command == bdq_pkg::CMD_DUMP) && !stat.empty;
    assign dump_step  = (state_reg == S_DUMP) && slot_free;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((accept && !dump_start) || dump_step)
        begin
            rsp_valid_next = 1'b1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (dump_start)
                begin
                    state_next = S_DUMP;
                end
            end
            S_DUMP:
            begin
                if (dump_step && stat.dump_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign ctrl.exec      = accept;
    assign ctrl.dump_step = dump_step;

endmodule

`default_nettype wire

// File: design/bounded_deque_with_drop_front.sv
// bounded_deque_with_drop_front: ring-buffer deque of 32-bit words, top level
// a result is registered and shows in the cycle after its command transfer; the
// first word of a dump passes through the ram read register, then the result register
// throughput: one non-dump command per cycle while results are taken; a dump holds the
// command side until its last entry is read, results one per cycle while taken, paced by the single RAM read port
// reset: head and count clear at once; the ring store is left as is, no clearing pass
// depends on bdq_pkg, bdq_req_if, bdq_rsp_if, bdq_ram, bdq_datapath, bdq_ctrl
`default_nettype none

module bounded_deque_with_drop_front (
    input wire logic clk,
    input wire logic rst_n,
    bdq_req_if.sink  req,
    bdq_rsp_if.source rsp
);

    bdq_pkg::bdq_ctrl_t ctrl;
    bdq_pkg::bdq_stat_t stat;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req.valid),
        .req_ready(req.ready),
        .command  (req.command),
        .rsp_valid(rsp.valid),
        .rsp_ready(rsp.ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    bdq_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .command    (req.command),
        .value      (req.value),
        .drop_count (req.drop_count),
        .stat       (stat),
        .status     (rsp.status),
        .value_out  (rsp.value_out),
        .entry_count(rsp.entry_count),
        .last       (rsp.last)
    );

    // a single-result command leaves a final result in the register next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.command != bdq_pkg::CMD_DUMP))
        |=> (rsp.valid && rsp.last))
    else $error("single-result command did not produce a final result");

    // only a dump produces several results, and those are all ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> ((rsp.status == bdq_pkg::ST_OK) && !req.ready))
    else $error("non-final result outside a dump");

    // data words appear only in ok results
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.value_out != '0)) |-> (rsp.status == bdq_pkg::ST_OK))
    else $error("data word in an error result");

    // the controller only steps a dump while no new command is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.dump_step |-> !ctrl.exec)
    else $error("dump step overlaps a command transfer");

endmodule

`default_nettype wire
